[design/indexed_insert_remove_list_core_defines.svh]
// Assertion macros shared by the list core.
`ifndef INDEXED_INSERT_REMOVE_LIST_CORE_DEFINES_SVH
`define INDEXED_INSERT_REMOVE_LIST_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IIRL_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("list core check failed");

// The consequent must hold in the cycle after the antecedent.
`define IIRL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("list core check failed");

`endif

[design/iirl_pkg.sv]
package iirl_pkg;

  // Default sizes of the list.
  localparam int DEPTH_DEFAULT      = 16;
  localparam int WORD_WIDTH_DEFAULT = 32;

  // Fixed widths of the request and response fields.
  localparam int OP_W     = 3;
  localparam int IDX_W    = 5;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Operation codes carried by a request.
  typedef enum logic [OP_W-1:0] {
    OP_INSERT  = 3'd0,
    OP_REMOVE  = 3'd1,
    OP_REPLACE = 3'd2,
    OP_READ    = 3'd3,
    OP_CLEAR   = 3'd4
  } op_t;

  // Status codes returned with each response.
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // What the cells do in a given cycle.
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_REMOVE,
    CMD_REPLACE
  } cell_cmd_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    cell_cmd_t          kind;
    logic [IDX_W-1:0]   idx;
  } cmd_t;

endpackage

[design/iirl_cell.sv]
// One storage cell of the list. It holds the entry at position POS and
// takes its next value from itself, its lower neighbor, its upper neighbor
// or the incoming word, as the broadcast command and its position decide.
module iirl_cell #(
  parameter int WORD_WIDTH = iirl_pkg::WORD_WIDTH_DEFAULT,
  parameter int POS        = 0
) (
  input  logic                  clk,
  input  iirl_pkg::cmd_t        cmd,
  input  logic [WORD_WIDTH-1:0] element,
  input  logic [WORD_WIDTH-1:0] left_word,
  input  logic [WORD_WIDTH-1:0] right_word,
  output logic [WORD_WIDTH-1:0] word,
  output logic                  hit
);

  // Compare width wide enough for both the index and this position.
  localparam int PW = ($clog2(POS + 2) > iirl_pkg::IDX_W) ?
                      $clog2(POS + 2) : iirl_pkg::IDX_W;
  localparam logic [PW-1:0] POS_L = PW'(POS);

  logic [PW-1:0] idx_w;
  logic          above;

  // Position of this cell relative to the addressed index.
  assign idx_w = PW'(cmd.idx);
  assign hit   = (idx_w == POS_L);
  assign above = (idx_w < POS_L);

  // Entry update; the entry itself needs no reset.
  always_ff @(posedge clk) begin
    unique case (cmd.kind)
      iirl_pkg::CMD_HOLD: begin
        word <= word;
      end
      iirl_pkg::CMD_INSERT: begin
        if (above) begin
          word <= left_word;
        end else if (hit) begin
          word <= element;
        end
      end
      iirl_pkg::CMD_REMOVE: begin
        if (above || hit) begin
          word <= right_word;
        end
      end
      iirl_pkg::CMD_REPLACE: begin
        if (hit) begin
          word <= element;
        end
      end
      default: begin
        word <= word;
      end
    endcase
  end

endmodule

[design/indexed_insert_remove_list_core.sv]
// Ordered list of up to DEPTH words held in a row of shift cells. Each
// request (insert, remove, replace, read or clear at an index) is decoded as
// it is taken and its response is registered and offered the next cycle; a
// new request is taken every cycle while the response register is empty or
// being drained, so the sustained rate is one request per cycle. Every cell
// loads from its neighbor, the incoming word or itself in the same cycle,
// which sets that figure. Reads select among at most the first 32 cells, the
// reach of the 5-bit index. The count is zero after reset; entries need no
// clearing, as only entries below the count are ever read.
`include "indexed_insert_remove_list_core_defines.svh"

module indexed_insert_remove_list_core #(
  parameter int DEPTH      = iirl_pkg::DEPTH_DEFAULT,
  parameter int WORD_WIDTH = iirl_pkg::WORD_WIDTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  logic [iirl_pkg::OP_W-1:0]      op,
  input  logic [iirl_pkg::IDX_W-1:0]     index,
  input  logic [iirl_pkg::DATA_W-1:0]    element,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output logic [iirl_pkg::DATA_W-1:0]    read_word,
  output logic [iirl_pkg::STATUS_W-1:0]  status,
  output logic [iirl_pkg::COUNT_W-1:0]   count
);

  localparam int LEN_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (LEN_W > iirl_pkg::IDX_W) ? LEN_W : iirl_pkg::IDX_W;
  localparam int READ_CELLS = (DEPTH < (1 << iirl_pkg::IDX_W)) ?
                              DEPTH : (1 << iirl_pkg::IDX_W);

  logic                    fire;
  logic [LEN_W-1:0]        length;
  logic [LEN_W-1:0]        length_next;
  logic [CMP_W-1:0]        idx_ext;
  logic [CMP_W-1:0]        len_ext;
  logic [CMP_W-1:0]        len_next_ext;
  logic [WORD_WIDTH-1:0]   word_in;
  logic [WORD_WIDTH-1:0]   words [DEPTH];
  logic [DEPTH-1:0]        hits;
  logic [WORD_WIDTH-1:0]   read_sel;
  logic [WORD_WIDTH-1:0]   read_word_next;
  iirl_pkg::cell_cmd_t     kind;
  iirl_pkg::status_t       status_next;
  iirl_pkg::cmd_t          cmd;

  // Handshake: the response register parts the two sides.
  assign req_ready = !rsp_valid || rsp_ready;
  assign fire      = req_valid && req_ready;

  assign word_in      = WORD_WIDTH'(element);
  assign idx_ext      = CMP_W'(index);
  assign len_ext      = CMP_W'(length);
  assign len_next_ext = CMP_W'(length_next);

  // Index select over the cells the index can reach.
  always_comb begin
    read_sel = '0;
    for (int k = 0; k < READ_CELLS; k++) begin
      if (hits[k]) begin
        read_sel = read_sel | words[k];
      end
    end
  end

  // Request decode: checks, new count and the command for the cells.
  always_comb begin
    kind           = iirl_pkg::CMD_HOLD;
    status_next    = iirl_pkg::ST_DONE;
    length_next    = length;
    read_word_next = '0;
    unique case (iirl_pkg::op_t'(op))
      iirl_pkg::OP_INSERT: begin
        if (idx_ext > len_ext) begin
          status_next = iirl_pkg::ST_RANGE;
        end else if (length == LEN_W'(DEPTH)) begin
          status_next = iirl_pkg::ST_FULL;
        end else begin
          kind        = iirl_pkg::CMD_INSERT;
          length_next = length + 1'b1;
        end
      end
      iirl_pkg::OP_REMOVE: begin
        if (idx_ext >= len_ext) begin
          status_next = iirl_pkg::ST_RANGE;
        end else begin
          kind        = iirl_pkg::CMD_REMOVE;
          length_next = length - 1'b1;
        end
      end
      iirl_pkg::OP_REPLACE: begin
        if (idx_ext >= len_ext) begin
          status_next = iirl_pkg::ST_RANGE;
        end else begin
          kind = iirl_pkg::CMD_REPLACE;
        end
      end
      iirl_pkg::OP_READ: begin
        if (idx_ext >= len_ext) begin
          status_next = iirl_pkg::ST_RANGE;
        end else begin
          read_word_next = iirl_pkg::DATA_W'(read_sel);
        end
      end
      iirl_pkg::OP_CLEAR: begin
        length_next = '0;
      end
      default: begin
        length_next = length;
      end
    endcase
  end

  // Cells act only on an accepted request.
  assign cmd.kind = fire ? kind : iirl_pkg::CMD_HOLD;
  assign cmd.idx  = index;

  // The chain of cells.
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [WORD_WIDTH-1:0] left_word;
    logic [WORD_WIDTH-1:0] right_word;

    if (k == 0) begin : g_first
      assign left_word = '0;
    end else begin : g_mid_lo
      assign left_word = words[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right_word = '0;
    end else begin : g_mid_hi
      assign right_word = words[k+1];
    end

    iirl_cell #(
      .WORD_WIDTH(WORD_WIDTH),
      .POS       (k)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .element   (word_in),
      .left_word (left_word),
      .right_word(right_word),
      .word      (words[k]),
      .hit       (hits[k])
    );
  end

  // Count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      length <= '0;
    end else if (fire) begin
      length <= length_next;
    end
  end

  // Response valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // Response payload.
  always_ff @(posedge clk) begin
    if (fire) begin
      read_word <= read_word_next;
      status    <= status_next;
      count     <= len_next_ext[iirl_pkg::COUNT_W-1:0];
    end
  end

  // A successful insert grows the list by exactly one entry.
  `IIRL_ASSERT_NEXT(a_insert_grows, clk, rst,
    fire && (op == iirl_pkg::OP_INSERT) && (status_next == iirl_pkg::ST_DONE),
    length == $past(length) + 1'b1)
  // A refused request leaves the count unchanged.
  `IIRL_ASSERT_NEXT(a_refused_holds, clk, rst,
    fire && (status_next != iirl_pkg::ST_DONE), $stable(length))
  // The count never exceeds the capacity.
  `IIRL_ASSERT_SAME(a_len_bound, clk, rst, 1'b1, length <= LEN_W'(DEPTH))
  // Every accepted request leaves a response waiting.
  `IIRL_ASSERT_NEXT(a_rsp_after_req, clk, rst, fire, rsp_valid)

endmodule
